// ----- hw/rtl/dttf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttf_pkg: shared types and constants for decimal text to fixed point
// Character codes, field widths, powers of ten and the bundles between the
// top level and the accumulator.
// ----------------------------------------------------------------------------
package dttf_pkg;

    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 64;
    localparam int FRAC_DIGITS_DEF = 8;

    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    // One input request as seen by the accumulator
    typedef struct packed {
        logic              take;
        logic              has_char;
        logic              last;
        logic [CHAR_W-1:0] char_code;
    } step_t;

    // Finished conversion for the result register
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ok;
    } res_t;

    // Ten to the n, modulo 2^64; used only at elaboration
    function automatic logic [VALUE_W-1:0] pow10(input int n);
        logic [VALUE_W-1:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/dttf_char_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttf_char_if: character channel
// Carries one text character per request, with its end marker.
// ----------------------------------------------------------------------------
interface dttf_char_if;
    logic                        valid;
    logic                        ready;
    logic [dttf_pkg::CHAR_W-1:0] char_code;
    logic                        has_char;
    logic                        last;

    modport source (output valid, output char_code, output has_char, output last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input last,
                    output ready);
endinterface

// ----- hw/rtl/dttf_res_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttf_res_if: result channel
// Carries one converted fixed-point value and its well-formed flag.
// ----------------------------------------------------------------------------
interface dttf_res_if;
    logic                         valid;
    logic                         ready;
    logic [dttf_pkg::VALUE_W-1:0] value;
    logic                         valid_res;

    modport source (output valid, output value, output valid_res, input ready);
    modport sink   (input valid, input value, input valid_res, output ready);
endinterface

// ----- hw/rtl/dttf_acc.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dttf_acc: character accumulator
// Folds one character per cycle, when taken, into a pre-scaled integer part
// and a padded fraction part, so the result is a single add at end of string.
// ----------------------------------------------------------------------------
module dttf_acc #(
    parameter int FRAC_DIGITS = dttf_pkg::FRAC_DIGITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  dttf_pkg::step_t step,
    output dttf_pkg::res_t  res
);

    localparam logic [63:0] SCALE  = dttf_pkg::pow10(FRAC_DIGITS);
    localparam int          FRAC_W = $clog2(SCALE);
    localparam int          CNT_W  = $clog2(FRAC_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(FRAC_DIGITS);

    // Integer part is kept already multiplied by 10^FRAC_DIGITS (mod 2^64)
    logic [63:0]       int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              in_frac_reg, in_frac_next;
    logic              bad_reg, bad_next;
    logic              seen_reg, seen_next;

    logic [FRAC_W-1:0] place_tbl [FRAC_DIGITS+1];
    logic [3:0]        digit;
    logic              is_dot;
    logic              is_digit;
    logic [63:0]       int_times10;
    logic [63:0]       int_digit;
    logic [FRAC_W+3:0] frac_prod;

    // Place value of the next fraction digit; zero once the fraction is full
    for (genvar g = 0; g <= FRAC_DIGITS; g++)
    begin : g_place
        if (g < FRAC_DIGITS)
        begin : g_used
            assign place_tbl[g] = FRAC_W'(dttf_pkg::pow10(FRAC_DIGITS - 1 - g));
        end
        else
        begin : g_full
            assign place_tbl[g] = '0;
        end
    end

    // Decode the character and form the digit terms
    always_comb
    begin
        is_dot      = (step.char_code == dttf_pkg::CHAR_DOT);
        is_digit    = (step.char_code >= dttf_pkg::CHAR_ZERO) &&
                      (step.char_code <= dttf_pkg::CHAR_NINE);
        digit       = 4'(step.char_code - dttf_pkg::CHAR_ZERO);
        int_times10 = {int_reg[60:0], 3'b000} + {int_reg[62:0], 1'b0};
        int_digit   = SCALE * {60'd0, digit};
        frac_prod   = (FRAC_W+4)'(place_tbl[cnt_reg]) * (FRAC_W+4)'(digit);
    end

    // Advance the parse state by one character
    always_comb
    begin
        int_next     = int_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        in_frac_next = in_frac_reg;
        bad_next     = bad_reg;
        seen_next    = seen_reg;
        if (step.take && step.has_char)
        begin
            seen_next = 1'b1;
            if (!bad_reg)
            begin
                if (is_dot)
                begin
                    if (in_frac_reg)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        in_frac_next = 1'b1;
                    end
                end
                else if (!is_digit)
                begin
                    bad_next = 1'b1;
                end
                else if (!in_frac_reg)
                begin
                    int_next = int_times10 + int_digit;
                end
                else if (cnt_reg < CNT_MAX)
                begin
                    frac_next = frac_reg + frac_prod[FRAC_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
        end
        res.ok    = seen_next && !bad_next;
        res.value = res.ok ? (int_next + 64'(frac_next)) : '0;
    end

    // Hold state; drop it after the end of each string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            in_frac_reg <= 1'b0;
            bad_reg     <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else if (step.take && step.last)
        begin
            int_reg     <= '0;
            frac_reg    <= '0;
            cnt_reg     <= '0;
            in_frac_reg <= 1'b0;
            bad_reg     <= 1'b0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            int_reg     <= int_next;
            frac_reg    <= frac_next;
            cnt_reg     <= cnt_next;
            in_frac_reg <= in_frac_next;
            bad_reg     <= bad_next;
            seen_reg    <= seen_next;
        end
    end

    // Fraction digits only exist after a dot
    a_frac_after_dot: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frac_reg |-> (cnt_reg == '0 && frac_reg == '0))
        else $error("fraction state without a dot");

    // Kept fraction stays below one whole unit
    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= CNT_MAX) && (64'(frac_reg) < SCALE))
        else $error("fraction accumulator out of range");

    // End of string leaves a clean state
    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (step.take && step.last) |=> (!seen_reg && !bad_reg && int_reg == '0))
        else $error("state not cleared after end of string");

    // An error can only follow a seen character
    a_bad_needs_char: assert property (@(posedge clk) disable iff (!rst_n)
        bad_reg |-> seen_reg)
        else $error("error flag without any character");

endmodule

// ----- hw/rtl/decimal_text_to_fixed_point_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top: decimal text to fixed-point converter
// Converts an unsigned decimal string, one character per request, to the
// number times 10^FRAC_DIGITS modulo 2^64, with a well-formed flag.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          notes
//  char_in   in   char_code[7:0], has_char, last   one request per character
//  res_out   out  value[63:0], valid_res           one request per last
//
//  One character per cycle unless stalled; the result appears in the cycle
//  after its last request is accepted, held in a single output register.
//  The accumulator does one multiply-by-ten add step a cycle while input moves.
//  Reset clears the parse state and the output valid flag; no clearing pass.
//  A result waiting in the output register stalls all input until it is taken.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_top #(
    parameter int FRAC_DIGITS = dttf_pkg::FRAC_DIGITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dttf_char_if.sink     char_in,
    dttf_res_if.source    res_out
);

    dttf_pkg::step_t step;
    dttf_pkg::res_t  acc_res;

    logic        res_valid_reg;
    logic [63:0] res_value_reg;
    logic        res_ok_reg;
    logic        take;

    // Accept while the output register is empty or being emptied
    assign char_in.ready = !res_valid_reg || res_out.ready;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        step.take      = take;
        step.has_char  = char_in.has_char;
        step.last      = char_in.last;
        step.char_code = char_in.char_code;
    end

    dttf_acc #(
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .res   (acc_res)
    );

    // Output register: load on end of string, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take && char_in.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_out.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && char_in.last)
        begin
            res_value_reg <= acc_res.value;
            res_ok_reg    <= acc_res.ok;
        end
    end

    assign res_out.valid     = res_valid_reg;
    assign res_out.value     = res_value_reg;
    assign res_out.valid_res = res_ok_reg;

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_out.ready) |-> !take)
        else $error("pending result would be overwritten");

    // End of string always produces a result next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && char_in.last) |=> res_valid_reg)
        else $error("missing result after end of string");

    // Invalid text reports a zero value
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ok_reg) |-> (res_value_reg == '0))
        else $error("invalid result with nonzero value");

endmodule

// ----- tb/decimal_text_to_fixed_point_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_top_test: converter testbench
// Feeds decimal strings one character per request: directed corner cases
// first, then random numbers with noise, wrap-around and truncation. A
// parse tracker predicts each fixed-point result and checks the output
// channel field by field. Both sides idle at random, and the output holds
// off once for a long stretch so the input stalls.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_top_test;

    localparam int          ITEM_TARGET = 600;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int          TAIL_CYCLES = 8;

    typedef struct {
        logic [dttf_pkg::VALUE_W-1:0] value;
        logic                         ok;
    } fixed_result_t;

    // Tracks the parse state and holds the fixed-point values still owed
    class fixed_point_ledger;
        logic [dttf_pkg::VALUE_W-1:0] int_part;
        logic [dttf_pkg::VALUE_W-1:0] frac_part;
        int unsigned                  frac_digits;
        bit                           saw_dot;
        bit                           saw_error;
        bit                           saw_char;
        fixed_result_t                pending_values[$];
        int unsigned                  mismatches;

        function new();
            clear_parse();
            mismatches = 0;
        endfunction

        function void clear_parse();
            int_part    = '0;
            frac_part   = '0;
            frac_digits = 0;
            saw_dot     = 1'b0;
            saw_error   = 1'b0;
            saw_char    = 1'b0;
        endfunction

        // Advance the parse for one accepted character request
        function void note_char(logic [dttf_pkg::CHAR_W-1:0] code, logic has, logic lst);
            fixed_result_t                r;
            logic [dttf_pkg::VALUE_W-1:0] padded;
            logic [dttf_pkg::VALUE_W-1:0] scale;
            if (has)
            begin
                saw_char = 1'b1;
                if (!saw_error)
                begin
                    if (code == dttf_pkg::CHAR_DOT)
                    begin
                        if (saw_dot)
                            saw_error = 1'b1;
                        else
                            saw_dot = 1'b1;
                    end
                    else if (code < dttf_pkg::CHAR_ZERO || code > dttf_pkg::CHAR_NINE)
                        saw_error = 1'b1;
                    else if (!saw_dot)
                        int_part = int_part * 64'd10 + 64'(code - dttf_pkg::CHAR_ZERO);
                    else if (frac_digits < dttf_pkg::FRAC_DIGITS_DEF)
                    begin
                        frac_part = frac_part * 64'd10 + 64'(code - dttf_pkg::CHAR_ZERO);
                        frac_digits++;
                    end
                end
            end
            if (lst)
            begin
                // pad a short fraction, then scale the integer part
                padded = frac_part;
                for (int k = frac_digits; k < dttf_pkg::FRAC_DIGITS_DEF; k++)
                    padded = padded * 64'd10;
                scale = 64'd1;
                for (int k = 0; k < dttf_pkg::FRAC_DIGITS_DEF; k++)
                    scale = scale * 64'd10;
                r.ok    = saw_char && !saw_error;
                r.value = r.ok ? int_part * scale + padded : '0;
                pending_values.push_back(r);
                clear_parse();
            end
        endfunction

        // Compare one accepted result with the oldest value owed
        function void check_value(logic [dttf_pkg::VALUE_W-1:0] value, logic valid_res);
            fixed_result_t exp_r;
            if (pending_values.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value=%0d valid_res=%0b",
                         $time, value, valid_res);
                mismatches++;
                return;
            end
            exp_r = pending_values.pop_front();
            if (value !== exp_r.value)
            begin
                $display("%0t: value mismatch, expected %0d, actual %0d",
                         $time, exp_r.value, value);
                mismatches++;
            end
            if (valid_res !== exp_r.ok)
            begin
                $display("%0t: valid_res mismatch, expected %0b, actual %0b",
                         $time, exp_r.ok, valid_res);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    bit   hold_request;

    fixed_point_ledger ledger;

    dttf_char_if char_ch ();
    dttf_res_if  res_ch ();

    decimal_text_to_fixed_point_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_ch),
        .res_out (res_ch)
    );

    always #5 clk = ~clk;

    // Note accepted requests on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_ch.valid && char_ch.ready)
                ledger.note_char(char_ch.char_code, char_ch.has_char, char_ch.last);
            if (res_ch.valid && res_ch.ready)
                ledger.check_value(res_ch.value, res_ch.valid_res);
        end
    end

    // Abort when no request moves on either channel for too long
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((char_ch.valid && char_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[decimal_text_to_fixed_point_top] ERROR");
        $finish;
    end

    // Drain results, with random stalls and one long hold-off
    initial
    begin
        int unsigned stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 18);
            if (stall != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    // Offer one character request and hold it until accepted
    task automatic send_char(input logic [dttf_pkg::CHAR_W-1:0] code, input logic has,
                             input logic lst);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            char_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_ch.valid     <= 1'b1;
        char_ch.char_code <= code;
        char_ch.has_char  <= has;
        char_ch.last      <= lst;
        @(posedge clk);
        while (!char_ch.ready)
            @(posedge clk);
    endtask

    // Send a string, ending on its final character or on a bare end marker
    task automatic send_text(input string s, input bit end_marker);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b1, !end_marker && (i == s.len() - 1));
        if (end_marker)
            send_char(8'h00, 1'b0, 1'b1);
    endtask

    // Build and send one random number, mostly well formed
    task automatic send_random_number(output int unsigned n_items);
        logic [dttf_pkg::CHAR_W-1:0] text[$];
        int unsigned                 n_int;
        int unsigned                 n_frac;
        bit                          end_marker;
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 5);
        repeat (n_int) text.push_back(8'(dttf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0)
        begin
            text.push_back(dttf_pkg::CHAR_DOT);
            n_frac = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 7);
            repeat (n_frac) text.push_back(8'(dttf_pkg::CHAR_ZERO + $urandom_range(0, 9)));
        end
        // corrupt some numbers with a stray code or an extra dot
        if ($urandom_range(0, 4) == 0)
        begin
            if ($urandom_range(0, 2) == 0)
                text.insert($urandom_range(0, text.size()), dttf_pkg::CHAR_DOT);
            else
                text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
        end
        end_marker = (text.size() == 0) || ($urandom_range(0, 1) == 1);
        foreach (text[i])
        begin
            if ($urandom_range(0, 7) == 0)
                send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_char(text[i], 1'b1, !end_marker && (i == text.size() - 1));
        end
        if (end_marker)
            send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        n_items = text.size() + (end_marker ? 1 : 0);
    endtask

    initial
    begin
        int unsigned items_sent;
        int unsigned n;
        bit          hold_done;
        clk               = 1'b0;
        rst_n             = 1'b0;
        char_ch.valid     = 1'b0;
        char_ch.char_code = '0;
        char_ch.has_char  = 1'b0;
        char_ch.last      = 1'b0;
        res_ch.ready      = 1'b0;
        no_idle           = 1'b0;
        hold_request      = 1'b0;
        hold_done         = 1'b0;
        items_sent        = 0;
        ledger            = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty string, lone dot, dot at either end
        send_text("", 1'b1);
        send_text(".", 1'b0);
        send_text("5.", 1'b0);
        send_text(".5", 1'b1);
        // second dot, high code then ignored digit, codes just outside the digits
        send_text("..", 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char("7", 1'b1, 1'b1);
        send_text("/", 1'b0);
        send_text(":", 1'b0);
        // request without a character inside a number
        send_char("9", 1'b1, 1'b0);
        send_char(8'h00, 1'b0, 1'b0);
        send_char("0", 1'b1, 1'b1);
        // fraction longer than kept, truncated
        send_text(".987654321", 1'b0);

        // random numbers, alternating idle and back-to-back stretches
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle = ~no_idle;
            if (!hold_done && items_sent >= ITEM_TARGET / 2)
            begin
                hold_request = 1'b1;
                no_idle      = 1'b1;
                hold_done    = 1'b1;
            end
            send_random_number(n);
            items_sent += n;
        end
        char_ch.valid <= 1'b0;

        // drain the remaining results
        while (ledger.pending_values.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0)
            $display("[decimal_text_to_fixed_point_top] OK");
        else
            $display("[decimal_text_to_fixed_point_top] ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dttf_pkg.sv
hw/rtl/dttf_char_if.sv
hw/rtl/dttf_res_if.sv
hw/rtl/dttf_acc.sv
hw/rtl/decimal_text_to_fixed_point_top.sv
tb/decimal_text_to_fixed_point_top_test.sv
